/* rtl/core/ria_pkg.sv */
package ria_pkg;

  localparam int MAX_POOL_INSTANCES = 16;
  localparam int NUM_CHANNELS       = 16;
  localparam int NUM_POOLS          = 4;
  localparam int COUNT_BITS_DEF     = 16;

  localparam int INST_BITS  = $clog2(MAX_POOL_INSTANCES);
  localparam int POOL_BITS  = $clog2(NUM_POOLS);
  localparam int CHAN_BITS  = $clog2(NUM_CHANNELS);
  localparam int CNT_BITS   = INST_BITS + 1;
  localparam int SLOT_BITS  = POOL_BITS + INST_BITS;
  localparam int NUM_SLOTS  = NUM_POOLS * MAX_POOL_INSTANCES;
  localparam int AFF_BITS   = CHAN_BITS + POOL_BITS;
  localparam int NUM_AFF    = NUM_CHANNELS * NUM_POOLS;
  localparam int IDX_BITS   = SLOT_BITS + 1;

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  typedef logic [2:0]           opcode_t;
  typedef logic [2:0]           status_t;
  typedef logic [POOL_BITS-1:0] pool_t;
  typedef logic [CHAN_BITS-1:0] chan_t;
  typedef logic [INST_BITS-1:0] inst_t;
  typedef logic [CNT_BITS-1:0]  size_t;
  typedef logic [1:0]           reg_idx_t;

  localparam opcode_t OP_CREATE  = 3'd0;
  localparam opcode_t OP_ALLOC   = 3'd1;
  localparam opcode_t OP_RELEASE = 3'd2;
  localparam opcode_t OP_REL_CH  = 3'd3;
  localparam opcode_t OP_SET_AFF = 3'd4;
  localparam opcode_t OP_CLR_AFF = 3'd5;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NONE_FREE = 3'd1;
  localparam status_t ST_NO_POOL   = 3'd2;
  localparam status_t ST_UNKNOWN   = 3'd3;
  localparam status_t ST_MISMATCH  = 3'd4;
  localparam status_t ST_EXISTS    = 3'd5;

  localparam reg_idx_t REG_MODE = 2'd0;
  localparam reg_idx_t REG_INIT = 2'd1;
  localparam reg_idx_t REG_MAX  = 2'd2;
  localparam reg_idx_t REG_GROW = 2'd3;

  localparam logic [1:0] MODE_FIRST    = 2'd0;
  localparam logic [1:0] MODE_AFFINITY = 2'd2;

  function automatic size_t clamp_size(input size_t v);
    return (v > size_t'(MAX_POOL_INSTANCES)) ? size_t'(MAX_POOL_INSTANCES) : v;
  endfunction

endpackage

/* rtl/core/resource_instance_allocator.sv */
// Resource instance allocator: keeps pools of interchangeable instances and serves one
// operation per input beat (create, allocate, release, release channel, set or clear
// affinity). Every input beat produces exactly one result beat.
// Input and output channels use valid/stall; a beat moves when valid is high and stall
// is low. The block takes one operation at a time and stalls its input while it works.
// Operations in steps: create zeroes every usage count of the new pool, allocate scans
// the pool's usage counts (an affinity hit skips the scan, a miss reads affinity first),
// release reads the owner table once, release channel reads the owner table once per
// slot, and affinity set/clear and refused or unknown operations go straight to the result.
// Allocation and release channel walk the usage-count and owner tables through their
// single read port, which the sequencer steps one entry per cycle.
// A finished result sits in the output register; the next operation is accepted while
// it waits. If the receiver stalls and a second result is finished, the block holds it
// and keeps its input stalled until the output register drains.
// Configuration is an APB-style port (registers at byte offsets 0, 4, 8, 12); the user
// must write it only while idle; the block does not enforce it. Synchronous reset clears
// pools, busy and affinity flags and restores register defaults; no clearing pass is needed.
module resource_instance_allocator #(
  parameter int COUNT_BITS = ria_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ria_pkg::opcode_t                  opcode,
  input  ria_pkg::pool_t                    pool_type,
  input  ria_pkg::chan_t                    channel,
  input  ria_pkg::inst_t                    instance_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ria_pkg::status_t                  status,
  output ria_pkg::inst_t                    granted_instance,
  output ria_pkg::size_t                    pool_size,
  output ria_pkg::size_t                    released_count,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ria_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [ria_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [ria_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import ria_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_AFF_RD, S_AFF_CHK, S_SCAN, S_PICK_RD, S_PICK_WR,
    S_REL_RD, S_REL_WR, S_RCH, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [1:0] cfg_mode;
  size_t      cfg_init;
  size_t      cfg_max;
  logic       cfg_grow;
  reg_idx_t   reg_idx;
  logic       cfg_wr;

  // pool state
  logic [NUM_SLOTS-1:0] busy;
  logic [NUM_POOLS-1:0] present;
  size_t                cnt [NUM_POOLS];
  logic [NUM_AFF-1:0]   aff_vld;

  // tables
  logic [COUNT_BITS-1:0] use_mem [NUM_SLOTS];
  chan_t                 own_mem [NUM_SLOTS];
  inst_t                 aff_mem [NUM_AFF];
  logic [COUNT_BITS-1:0] use_rd;
  chan_t                 own_rd;
  inst_t                 aff_rd;

  logic                  use_we;
  logic [SLOT_BITS-1:0]  use_waddr;
  logic [SLOT_BITS-1:0]  use_raddr;
  logic [COUNT_BITS-1:0] use_wdata;
  logic [COUNT_BITS-1:0] use_base;
  logic [SLOT_BITS-1:0]  own_raddr;
  logic [SLOT_BITS-1:0]  pick_slot;
  logic                  aff_we;
  logic [AFF_BITS-1:0]   aff_waddr;
  logic [AFF_BITS-1:0]   aff_raddr;

  // operation in flight
  opcode_t op_r;
  pool_t   pool_r;
  chan_t   ch_r;
  inst_t   id_r;
  logic    have_r;
  status_t res_status;
  inst_t   res_granted;
  size_t   res_released;

  // scan bookkeeping
  logic [IDX_BITS-1:0]   idx;
  logic                  cmp_vld;
  logic [SLOT_BITS-1:0]  cmp_idx;
  logic                  found;
  inst_t                 best_idx;
  logic [COUNT_BITS-1:0] best_use;
  logic                  pick_new;

  logic                  accept;
  logic                  scan_issue;
  logic                  scan_take;
  pool_t                 rch_pool;
  inst_t                 rch_inst;
  logic                  rch_hit;
  logic                  aff_hit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MODE: prdata = APB_DATA_BITS'(cfg_mode);
      REG_INIT: prdata = APB_DATA_BITS'(cfg_init);
      REG_MAX:  prdata = APB_DATA_BITS'(cfg_max);
      REG_GROW: prdata = APB_DATA_BITS'(cfg_grow);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode <= 2'd1;
      cfg_init <= size_t'(2);
      cfg_max  <= size_t'(8);
      cfg_grow <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE: cfg_mode <= pwdata[1:0];
        REG_INIT: cfg_init <= pwdata[CNT_BITS-1:0];
        REG_MAX:  cfg_max  <= pwdata[CNT_BITS-1:0];
        REG_GROW: cfg_grow <= pwdata[0];
        default:  cfg_mode <= cfg_mode;
      endcase
    end
  end

  // ---------------- table ports ----------------
  assign pick_slot = {pool_r, best_idx};
  assign use_base  = pick_new ? '0 : use_rd;
  assign use_we    = (state == S_CLEAR) || (state == S_PICK_WR);
  assign use_waddr = (state == S_CLEAR) ? {pool_r, idx[INST_BITS-1:0]} : pick_slot;
  assign use_wdata = (state == S_CLEAR) ? '0 :
                     ((use_base == '1) ? use_base : use_base + COUNT_BITS'(1));
  assign use_raddr = (state == S_SCAN) ? {pool_r, idx[INST_BITS-1:0]} : pick_slot;
  assign own_raddr = (state == S_RCH) ? idx[SLOT_BITS-1:0] : {pool_r, id_r};
  assign aff_we    = accept && (opcode == OP_SET_AFF);
  assign aff_waddr = {channel, pool_type};
  assign aff_raddr = {ch_r, pool_r};

  always_ff @(posedge clk) begin
    if (use_we) use_mem[use_waddr] <= use_wdata;
    use_rd <= use_mem[use_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_PICK_WR) own_mem[pick_slot] <= ch_r;
    own_rd <= own_mem[own_raddr];
  end

  always_ff @(posedge clk) begin
    if (aff_we) aff_mem[aff_waddr] <= instance_id;
    aff_rd <= aff_mem[aff_raddr];
  end

  // ---------------- scan helpers ----------------
  assign scan_issue = (idx < IDX_BITS'(cnt[pool_r]));
  assign scan_take  = cmp_vld && !busy[cmp_idx] &&
                      (!found || ((cfg_mode != MODE_FIRST) && (use_rd < best_use)));
  assign rch_pool   = cmp_idx[SLOT_BITS-1:INST_BITS];
  assign rch_inst   = cmp_idx[INST_BITS-1:0];
  assign rch_hit    = cmp_vld && present[rch_pool] && ({1'b0, rch_inst} < cnt[rch_pool]) &&
                      busy[cmp_idx] && (own_rd == ch_r);
  assign aff_hit    = aff_vld[{ch_r, pool_r}] && ({1'b0, aff_rd} < cnt[pool_r]) &&
                      !busy[{pool_r, aff_rd}];

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      busy      <= '0;
      present   <= '0;
      aff_vld   <= '0;
      cmp_vld   <= 1'b0;
      for (int q = 0; q < NUM_POOLS; q++) cnt[q] <= '0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r         <= opcode;
            pool_r       <= pool_type;
            ch_r         <= channel;
            id_r         <= instance_id;
            have_r       <= present[pool_type];
            res_granted  <= '0;
            res_released <= '0;
            idx          <= '0;
            cmp_vld      <= 1'b0;
            found        <= 1'b0;
            pick_new     <= 1'b0;
            case (opcode)
              OP_CREATE: begin
                if (present[pool_type]) begin
                  res_status <= ST_EXISTS;
                  state      <= S_DONE;
                end else begin
                  present[pool_type] <= 1'b1;
                  cnt[pool_type]     <= clamp_size(cfg_init);
                  for (int i = 0; i < MAX_POOL_INSTANCES; i++)
                    busy[{pool_type, INST_BITS'(i)}] <= 1'b0;
                  res_status <= ST_OK;
                  state      <= S_CLEAR;
                end
              end
              OP_ALLOC: begin
                if (!present[pool_type]) begin
                  res_status <= ST_NO_POOL;
                  state      <= S_DONE;
                end else if (cfg_mode == MODE_AFFINITY) begin
                  res_status <= ST_OK;
                  state      <= S_AFF_RD;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SCAN;
                end
              end
              OP_RELEASE: begin
                if (!present[pool_type]) begin
                  res_status <= ST_NO_POOL;
                  state      <= S_DONE;
                end else if ({1'b0, instance_id} >= cnt[pool_type]) begin
                  res_status <= ST_UNKNOWN;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_REL_RD;
                end
              end
              OP_REL_CH: begin
                res_status <= ST_OK;
                state      <= S_RCH;
              end
              OP_SET_AFF: begin
                aff_vld[{channel, pool_type}] <= 1'b1;
                res_status <= ST_OK;
                state      <= S_DONE;
              end
              OP_CLR_AFF: begin
                for (int q = 0; q < NUM_POOLS; q++)
                  aff_vld[{channel, POOL_BITS'(q)}] <= 1'b0;
                res_status <= ST_OK;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end

        // zero the new pool's usage counts, one entry a cycle
        S_CLEAR: begin
          idx <= idx + IDX_BITS'(1);
          if (idx == IDX_BITS'(MAX_POOL_INSTANCES - 1)) state <= S_DONE;
        end

        S_AFF_RD: state <= S_AFF_CHK;

        S_AFF_CHK: begin
          if (aff_hit) begin
            best_idx <= aff_rd;
            state    <= S_PICK_RD;
          end else begin
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (scan_issue) begin
            cmp_vld <= 1'b1;
            cmp_idx <= {pool_r, idx[INST_BITS-1:0]};
            idx     <= idx + IDX_BITS'(1);
          end else begin
            cmp_vld <= 1'b0;
          end
          if (scan_take) begin
            found    <= 1'b1;
            best_idx <= cmp_idx[INST_BITS-1:0];
            best_use <= use_rd;
          end
          if (!scan_issue && !cmp_vld) begin
            if (found) begin
              state <= S_PICK_RD;
            end else if (cfg_grow && (cnt[pool_r] < clamp_size(cfg_max))) begin
              // grow by one fresh instance and hand it out
              best_idx    <= cnt[pool_r][INST_BITS-1:0];
              pick_new    <= 1'b1;
              cnt[pool_r] <= cnt[pool_r] + size_t'(1);
              state       <= S_PICK_RD;
            end else begin
              res_status <= ST_NONE_FREE;
              state      <= S_DONE;
            end
          end
        end

        S_PICK_RD: state <= S_PICK_WR;

        S_PICK_WR: begin
          busy[pick_slot] <= 1'b1;
          res_granted     <= best_idx;
          state           <= S_DONE;
        end

        S_REL_RD: state <= S_REL_WR;

        S_REL_WR: begin
          if (!busy[{pool_r, id_r}] || (own_rd != ch_r)) res_status <= ST_MISMATCH;
          busy[{pool_r, id_r}] <= 1'b0;
          state <= S_DONE;
        end

        // walk every slot of every pool, freeing the channel's instances
        S_RCH: begin
          if (idx < IDX_BITS'(NUM_SLOTS)) begin
            cmp_vld <= 1'b1;
            cmp_idx <= idx[SLOT_BITS-1:0];
            idx     <= idx + IDX_BITS'(1);
          end else begin
            cmp_vld <= 1'b0;
          end
          if (rch_hit) begin
            busy[cmp_idx] <= 1'b0;
            if (res_released != '1) res_released <= res_released + size_t'(1);
          end
          if ((idx == IDX_BITS'(NUM_SLOTS)) && !cmp_vld) state <= S_DONE;
        end

        // hold the result until the output register is free
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            status           <= res_status;
            granted_instance <= res_granted;
            pool_size        <= have_r ? cnt[pool_r] : '0;
            released_count   <= res_released;
            state            <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result beat appeared without a finished operation");

  a_grant_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK_WR) |-> ({1'b0, best_idx} < cnt[pool_r]))
    else $error("granted instance lies outside the pool");

  a_released_only_rch: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (res_released != '0)) |-> (op_r == OP_REL_CH))
    else $error("released count set by an operation other than release channel");

  a_grant_was_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK_WR) |-> !busy[pick_slot])
    else $error("allocation picked a busy instance");

endmodule
